@@ design/mdbe_pkg.sv @@
// ----------------------------------------------------------------------------
// mdbe_pkg: shared types and constants
// Widths, result kinds and controller states of the block encoder.
// ----------------------------------------------------------------------------
package mdbe_pkg;

   localparam int BLOCK_SIZE_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int VALUE_W         = 17;
   localparam int COUNT_W         = 7;
   localparam int BITMAP_W        = 32;
   localparam int KIND_W          = 3;
   localparam int THR_W           = 7;
   localparam logic [THR_W-1:0] THR_RESET = 7'd40;
   localparam logic [THR_W-1:0] THR_MIN   = 7'd3;
   localparam int PAD_VALUE       = -10;

   typedef enum logic [KIND_W-1:0] {
      KIND_MODE   = 3'd0,
      KIND_BMAP1  = 3'd1,
      KIND_BMAP2  = 3'd2,
      KIND_RESID  = 3'd3,
      KIND_FIRST  = 3'd4,
      KIND_DELTA  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_PAD,
      ST_SCAN,
      ST_HDR,
      ST_BMAP1,
      ST_BMAP2,
      ST_BODY
   } state_type;

   typedef enum logic [1:0] {
      SH_HOLD,
      SH_LOAD,
      SH_ROT
   } shift_op_type;

   typedef struct packed {
      shift_op_type op;
      logic         bump;
   } cell_ctl_type;

endpackage

@@ design/mdbe_if.sv @@
// ----------------------------------------------------------------------------
// mdbe_req_if / mdbe_rsp_if / mdbe_csr_if: item channels
// Valid/ready channels for input samples, result items and the register.
// ----------------------------------------------------------------------------
interface mdbe_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, req_type, sample, input ready);
   modport sink   (input valid, req_type, sample, output ready);
endinterface

interface mdbe_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [16:0] value;
   logic [31:0]        bitmap;
   logic               last;
   modport source (output valid, kind, value, bitmap, last, input ready);
   modport sink   (input valid, kind, value, bitmap, last, output ready);
endinterface

interface mdbe_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ design/mdbe_cell.sv @@
// ----------------------------------------------------------------------------
// mdbe_cell: one sample cell
// Holds a sample and its match count; shifts both to the next cell.
// ----------------------------------------------------------------------------
module mdbe_cell
   import mdbe_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cell_ctl_type                  ctl,
   input  logic signed [SAMPLE_BITS-1:0] new_sample,
   input  logic signed [SAMPLE_BITS-1:0] prev_sample,
   input  logic [COUNT_W-1:0]            prev_count,
   input  logic                          prev_valid,
   input  logic                          clear,
   output logic signed [SAMPLE_BITS-1:0] sample_q,
   output logic [COUNT_W-1:0]            count_q,
   output logic                          valid_q
);
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic                          valid_ff, valid_in;
   logic                          hit;

   assign hit = valid_ff && (sample_ff == new_sample);

   always_comb begin
      sample_in = sample_ff;
      count_in  = count_ff;
      valid_in  = valid_ff;
      case (ctl.op)
         SH_LOAD: begin
            sample_in = prev_sample;
            // the count travels with its sample and picks up a later equal item
            count_in  = prev_count
                        + COUNT_W'(ctl.bump && prev_valid && (prev_sample == new_sample));
            valid_in  = prev_valid;
         end
         SH_ROT: begin
            sample_in = prev_sample;
            count_in  = prev_count;
         end
         default: begin
            if (ctl.bump && hit) count_in = count_ff + 1'b1;
         end
      endcase
      if (clear) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      count_ff  <= count_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   assign sample_q = sample_ff;
   assign count_q  = count_ff;
   assign valid_q  = valid_ff;
endmodule

@@ design/mode_or_delta_block_encoder.sv @@
// After a block's 64th sample is accepted, the chain rotates once to find
// the mode and once to build the bitmaps, then loads the first result (the
// mode item, or in delta coding the first sample) and rotates to emit the rest.
// Throughput: one sample per cycle while filling; no sample is taken until
// the block is emitted, and output stalls hold emission back.
// A flush pads one cell per cycle. Reset empties the chain, threshold 40.
// ----------------------------------------------------------------------------
// mode_or_delta_block_encoder: block mode-sparse / delta encoder
// 64-cell shift chain with per-cell match counts, scan and emit control.
// ----------------------------------------------------------------------------
module mode_or_delta_block_encoder
   import mdbe_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mdbe_req_if.sink    req,
   mdbe_rsp_if.source  rsp,
   mdbe_csr_if.sink    csr
);
   localparam int N  = BLOCK_SIZE_DEF;
   localparam int IW = $clog2(N);

   state_type                     state_ff, state_in;
   logic [THR_W-1:0]              thr_ff;
   logic [IW:0]                   cnt_ff, cnt_in;
   logic [COUNT_W-1:0]            best_ff, best_in;
   logic signed [SAMPLE_BITS-1:0] mode_ff, mode_in, prevs_ff, prevs_in;
   logic [BITMAP_W-1:0]           bm1_ff, bm1_in, bm2_ff, bm2_in;
   logic [COUNT_W-1:0]            nz_ff, nz_in;
   logic                          dmode_ff, dmode_in;
   logic                          ov_ff, ov_in;
   logic [KIND_W-1:0]             okind_ff, okind_in;
   logic signed [VALUE_W-1:0]     oval_ff, oval_in;
   logic [BITMAP_W-1:0]           obm_ff, obm_in;
   logic                          olast_ff, olast_in;

   cell_ctl_type                  ctl;
   logic signed [SAMPLE_BITS-1:0] in_s;
   logic                          clear;
   logic signed [SAMPLE_BITS-1:0] s_q [N];
   logic [COUNT_W-1:0]            c_q [N];
   logic                          v_q [N];
   logic signed [SAMPLE_BITS-1:0] head;
   logic [THR_W-1:0]              thr_eff;
   logic                          ne, out_free, take;

   // cell 0 receives new samples; cell N-1 is the chain head (oldest sample)
   for (genvar g = 0; g < N; g++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] ps;
      logic [COUNT_W-1:0]            pc;
      logic                          pv;
      if (g == 0) begin : g_first
         // a new item starts at zero and counts its own match in the cell
         assign ps = (ctl.op == SH_ROT) ? s_q[N-1] : in_s;
         assign pc = (ctl.op == SH_ROT) ? c_q[N-1] : '0;
         assign pv = 1'b1;
      end else begin : g_rest
         assign ps = s_q[g-1];
         assign pc = c_q[g-1];
         assign pv = v_q[g-1];
      end
      mdbe_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
         .clock(clock), .reset(reset), .ctl(ctl), .new_sample(in_s),
         .prev_sample(ps), .prev_count(pc), .prev_valid(pv), .clear(clear),
         .sample_q(s_q[g]), .count_q(c_q[g]), .valid_q(v_q[g])
      );
   end

   assign head    = s_q[N-1];
   assign thr_eff = (thr_ff < THR_MIN) ? THR_MIN : thr_ff;
   assign ne      = (head != mode_ff);
   assign out_free = !ov_ff || rsp.ready;

   assign req.ready = (state_ff == ST_FILL);
   assign csr.ready = 1'b1;
   assign take      = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= THR_RESET;
      else if (csr.valid) thr_ff <= csr.data;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      best_in  = best_ff;
      mode_in  = mode_ff;
      prevs_in = prevs_ff;
      bm1_in   = bm1_ff;
      bm2_in   = bm2_ff;
      nz_in    = nz_ff;
      dmode_in = dmode_ff;
      ov_in    = ov_ff && !rsp.ready;
      okind_in = okind_ff;
      oval_in  = oval_ff;
      obm_in   = obm_ff;
      olast_in = olast_ff;
      ctl      = '{op: SH_HOLD, bump: 1'b0};
      in_s     = req.sample;
      clear    = 1'b0;
      case (state_ff)
         ST_FILL: begin
            if (take && !req.req_type) begin
               ctl = '{op: SH_LOAD, bump: 1'b1};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == (IW+1)'(N-1)) begin
                  state_in = ST_SCAN;
                  cnt_in   = '0;
                  best_in  = '0;
               end
            end else if (take && cnt_ff != '0) begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            in_s   = SAMPLE_BITS'(PAD_VALUE);
            ctl    = '{op: SH_LOAD, bump: 1'b1};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (IW+1)'(N-1)) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
               best_in  = '0;
            end
         end
         ST_SCAN: begin
            ctl = '{op: SH_ROT, bump: 1'b0};
            if (c_q[N-1] > best_ff || (c_q[N-1] == best_ff && head < mode_ff)
                || cnt_ff == '0) begin
               best_in = c_q[N-1];
               mode_in = head;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (IW+1)'(N-1)) begin
               state_in = ST_HDR;
               cnt_in   = '0;
            end
         end
         ST_HDR: begin
            // mode known; one rotation pass builds bitmaps
            dmode_in = (best_ff < thr_eff);
            ctl = '{op: SH_ROT, bump: 1'b0};
            if (cnt_ff == '0) begin
               bm1_in = '0;
               bm2_in = '0;
               nz_in  = '0;
            end
            if (ne) begin
               nz_in = ((cnt_ff == '0) ? '0 : nz_ff) + 1'b1;
               if (cnt_ff[IW-1] == 1'b0)
                  bm1_in = ((cnt_ff == '0) ? '0 : bm1_ff)
                           | (BITMAP_W'(1) << (5'd31 - cnt_ff[4:0]));
               else
                  bm2_in = bm2_ff | (BITMAP_W'(1) << (5'd31 - cnt_ff[4:0]));
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (IW+1)'(N-1)) begin
               cnt_in   = '0;
               state_in = (best_ff < thr_eff) ? ST_BODY : ST_BMAP1;
               if (out_free && !(best_ff < thr_eff)) begin
                  ov_in = 1'b1; okind_in = KIND_MODE;
                  oval_in = VALUE_W'(mode_ff); obm_in = '0; olast_in = 1'b0;
               end else if (!(best_ff < thr_eff)) begin
                  state_in = ST_BMAP1;
                  cnt_in   = (IW+1)'(N);
               end
            end
         end
         ST_BMAP1: begin
            if (out_free) begin
               ov_in = 1'b1; olast_in = 1'b0; oval_in = '0;
               if (cnt_ff == (IW+1)'(N)) begin
                  okind_in = KIND_MODE; oval_in = VALUE_W'(mode_ff); obm_in = '0;
                  cnt_in   = '0;
               end else begin
                  okind_in = KIND_BMAP1; obm_in = bm1_ff;
                  state_in = ST_BMAP2;
               end
            end
         end
         ST_BMAP2: begin
            if (out_free) begin
               ov_in = 1'b1; okind_in = KIND_BMAP2; oval_in = '0;
               obm_in = bm2_ff; olast_in = (nz_ff == '0);
               state_in = (nz_ff == '0) ? ST_FILL : ST_BODY;
               if (nz_ff == '0) clear = 1'b1;
            end
         end
         ST_BODY: begin
            if (out_free) begin
               ctl = '{op: SH_ROT, bump: 1'b0};
               cnt_in   = cnt_ff + 1'b1;
               prevs_in = head;
               obm_in   = '0;
               if (dmode_ff) begin
                  ov_in = 1'b1;
                  okind_in = (cnt_ff == '0) ? KIND_FIRST : KIND_DELTA;
                  oval_in  = (cnt_ff == '0) ? VALUE_W'(head)
                             : VALUE_W'(VALUE_W'(head) - VALUE_W'(prevs_ff));
                  olast_in = (cnt_ff == (IW+1)'(N-1));
               end else if (ne) begin
                  ov_in = 1'b1; okind_in = KIND_RESID;
                  oval_in  = VALUE_W'(VALUE_W'(head) - VALUE_W'(mode_ff));
                  nz_in    = nz_ff - 1'b1;
                  olast_in = (nz_ff == COUNT_W'(1));
               end
               if (cnt_ff == (IW+1)'(N-1)) begin
                  state_in = ST_FILL;
                  cnt_in   = '0;
                  clear    = 1'b1;
               end
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         cnt_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
      end
      best_ff  <= best_in;
      mode_ff  <= mode_in;
      prevs_ff <= prevs_in;
      bm1_ff   <= bm1_in;
      bm2_ff   <= bm2_in;
      nz_ff    <= nz_in;
      dmode_ff <= dmode_in;
      okind_ff <= okind_in;
      oval_ff  <= oval_in;
      obm_ff   <= obm_in;
      olast_ff <= olast_in;
   end

   assign rsp.valid  = ov_ff;
   assign rsp.kind   = okind_ff;
   assign rsp.value  = oval_ff;
   assign rsp.bitmap = obm_ff;
   assign rsp.last   = olast_ff;
endmodule

@@ bench/mode_or_delta_block_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// mode_or_delta_block_encoder_tb: block encoder self-checking bench
// Streams sample and flush items through the encoder. Each accepted item is
// run through an in-bench encoder model, and every result item is checked
// in order against it. The run covers several thresholds and idle/stall
// mixes, plus a long receiver hold-off.
// ----------------------------------------------------------------------------
module mode_or_delta_block_encoder_tb;
   import mdbe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        flush;
      logic [15:0] sample;
   } req_item_type;

   typedef struct {
      kind_type           kind;
      logic signed [16:0] value;
      logic [31:0]        bitmap;
      logic               last;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mdbe_req_if #(.SAMPLE_BITS(16)) req ();
   mdbe_rsp_if rsp ();
   mdbe_csr_if csr ();

   mode_or_delta_block_encoder dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   always #2 clock = ~clock;

   req_item_type pending_q[$];
   rsp_item_type encoded_q[$];
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_left      = 0;
   int          errors         = 0;
   logic [6:0]  threshold      = THR_RESET;
   logic [15:0] block_buf[64];
   int          block_fill     = 0;

   task automatic encode_block();
      int thr, best, cnt, nz, seen;
      logic signed [15:0] mode;
      logic [31:0] bm1, bm2;
      rsp_item_type r;
      thr  = (threshold < THR_MIN) ? THR_MIN : threshold;
      best = 0;
      mode = 0;
      for (int i = 0; i < 64; i++) begin
         cnt = 0;
         for (int j = 0; j < 64; j++) if (block_buf[j] == block_buf[i]) cnt++;
         if (cnt > best || (cnt == best && $signed(block_buf[i]) < mode)) begin
            best = cnt;
            mode = block_buf[i];
         end
      end
      if (best >= thr) begin
         bm1 = '0;
         bm2 = '0;
         nz  = 0;
         for (int i = 0; i < 64; i++) begin
            if (block_buf[i] != mode) begin
               nz++;
               if (i < 32) bm1[31-i] = 1'b1;
               else bm2[63-i] = 1'b1;
            end
         end
         encoded_q.push_back('{KIND_MODE, 17'(mode), '0, 1'b0});
         encoded_q.push_back('{KIND_BMAP1, '0, bm1, 1'b0});
         encoded_q.push_back('{KIND_BMAP2, '0, bm2, nz == 0});
         seen = 0;
         for (int i = 0; i < 64; i++) begin
            if (block_buf[i] != mode) begin
               seen++;
               r.kind   = KIND_RESID;
               r.value  = 17'($signed(block_buf[i])) - 17'(mode);
               r.bitmap = '0;
               r.last   = (seen == nz);
               encoded_q.push_back(r);
            end
         end
      end else begin
         encoded_q.push_back('{KIND_FIRST, 17'($signed(block_buf[0])), '0, 1'b0});
         for (int i = 1; i < 64; i++) begin
            r.kind   = KIND_DELTA;
            r.value  = 17'($signed(block_buf[i])) - 17'($signed(block_buf[i-1]));
            r.bitmap = '0;
            r.last   = (i == 63);
            encoded_q.push_back(r);
         end
      end
      block_fill = 0;
   endtask

   task automatic accept_item(req_item_type it);
      if (!it.flush) begin
         block_buf[block_fill] = it.sample;
         block_fill++;
         if (block_fill == 64) encode_block();
      end else if (block_fill != 0) begin
         while (block_fill < 64) begin
            block_buf[block_fill] = 16'(PAD_VALUE);
            block_fill++;
         end
         encode_block();
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            accept_item(pending_q.pop_front());
         end
         if (!req.valid || req.ready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req.valid    <= 1'b1;
               req.req_type <= pending_q[0].flush;
               req.sample   <= pending_q[0].sample;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      rsp_item_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (encoded_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result item kind=%0d", rsp.kind);
            end else begin
               e = encoded_q.pop_front();
               if (rsp.kind !== e.kind || rsp.value !== e.value ||
                   rsp.bitmap !== e.bitmap || rsp.last !== e.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch exp k=%0d v=%0d b=%h l=%b got k=%0d v=%0d b=%h l=%b",
                              e.kind, e.value, e.bitmap, e.last,
                              rsp.kind, rsp.value, rsp.bitmap, rsp.last);
               end
            end
         end
         rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) if (hold_left > 0) hold_left <= hold_left - 1;

   task automatic push_sample(logic [15:0] s);
      pending_q.push_back('{1'b0, s});
   endtask

   task automatic push_flush();
      pending_q.push_back('{1'b1, 16'h0});
   endtask

   task automatic write_threshold(logic [6:0] t);
      csr.data  <= t;
      csr.valid <= 1'b1;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      threshold = t;
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || req.valid || encoded_q.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // mostly mode-heavy runs with random content, some noise and flushes
   task automatic random_items(int count);
      int n, kind, reps;
      logic [15:0] base, alt;
      n = 0;
      while (n < count) begin
         kind = $urandom_range(9);
         base = 16'($urandom);
         alt  = 16'($urandom);
         reps = $urandom_range(1, 64);
         if (reps > count - n) reps = count - n;
         for (int i = 0; i < reps; i++) begin
            case (kind)
               0, 1: push_sample(16'($urandom));
               2: push_sample(($urandom_range(1)) ? base : alt);
               default: push_sample(($urandom_range(99) < 70) ? base :
                                    base + 16'($urandom_range(0, 6)) - 16'd3);
            endcase
         end
         n += reps;
         if ($urandom_range(3) == 0) begin
            push_flush();
            n++;
         end
      end
   endtask

   initial begin
      req.valid    = 1'b0;
      req.req_type = 1'b0;
      req.sample   = '0;
      rsp.ready    = 1'b0;
      csr.valid    = 1'b0;
      csr.data     = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty flushes, extremes, padded partial block at reset threshold
      push_flush();
      push_sample(16'h8000);
      push_sample(16'h7fff);
      push_sample(16'h8000);
      push_sample(16'h0000);
      push_sample(16'hffff);
      push_sample(16'hfff6);
      push_sample(16'h5555);
      push_sample(16'haaaa);
      push_flush();
      push_flush();
      drain();

      // small threshold clamps to 3; padding becomes the mode
      write_threshold(7'd0);
      for (int i = 0; i < 10; i++) push_sample(16'($urandom));
      push_flush();
      drain();

      write_threshold(7'd3);
      random_items(40);
      push_flush();
      drain();

      send_idle_pct = 49;
      write_threshold(7'd64);
      for (int i = 0; i < 64; i++) push_sample(16'h0123);
      random_items(30);
      push_flush();
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 49;
      write_threshold(7'd127);
      random_items(30);
      push_flush();
      drain();

      send_idle_pct  = 11;
      recv_stall_pct = 11;
      write_threshold(7'd40);
      hold_left = 600;
      random_items(70);
      push_flush();
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_threshold(7'($urandom_range(3, 64)));
      random_items(20);
      push_flush();
      drain();

      if (errors == 0 && encoded_q.size() == 0) begin
         $display("mode_or_delta_block_encoder verification clean");
      end else begin
         $display("mode_or_delta_block_encoder verification failed");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("mode_or_delta_block_encoder verification failed");
      $finish;
   end

endmodule
